// ----- hdl/smx_pkg.sv -----
// package: opcodes, result codes, stack sizing and controller/datapath interface types
`timescale 1ns / 1ps

package smx_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int WORD_W      = 32;
  localparam int DEPTH_W     = 4;
  localparam int CNT_W       = $clog2(WORD_W + 1);

  // opcodes
  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_MOD   = 8'd6;
  localparam logic [7:0] OP_RDINT = 8'd7;
  localparam logic [7:0] OP_WRINT = 8'd8;
  localparam logic [7:0] OP_RDCHR = 8'd9;
  localparam logic [7:0] OP_WRCHR = 8'd10;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_OVF     = 3'd3;
  localparam logic [2:0] ST_UNF     = 3'd4;
  localparam logic [2:0] ST_DIVZ    = 3'd5;

  // write kinds
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_INT  = 2'd1;
  localparam logic [1:0] WK_CHR  = 2'd2;

  // alu result select
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_MUL = 3'd2;
  localparam logic [2:0] ALU_DIV = 3'd3;
  localparam logic [2:0] ALU_MOD = 3'd4;

  typedef struct packed {
    logic       capture;
    logic       push;
    logic       reduce;
    logic [2:0] alu_sel;
    logic       pop;
    logic       set_halt;
    logic       set_res;
    logic [2:0] res_status;
    logic [1:0] res_kind;
    logic       mul_start;
    logic       div_start;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic       halted;
    logic       sp_full;
    logic       sp_lt1;
    logic       sp_lt2;
    logic       divisor_zero;
    logic       div_busy;
  } dp_stat_t;

endpackage

// ----- hdl/smx_datapath.sv -----
// datapath: operand stack memory, stack pointer, alu, multiplier, serial divider, result regs
`timescale 1ns / 1ps

module smx_datapath
  import smx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [7:0]        in_command,
  input  logic [23:0]       in_immediate,
  input  logic [WORD_W-1:0] in_read_value,
  output logic [1:0]        out_write_kind,
  output logic [WORD_W-1:0] out_write_value,
  output logic [2:0]        out_status,
  output logic [DEPTH_W-1:0] out_depth
);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  logic [7:0]        cmd_r;
  logic [23:0]       imm_r;
  logic [WORD_W-1:0] rv_r;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              halted_r, halted_nxt;
  logic [WORD_W-1:0] rd_a_r, rd_b_r;
  logic [WORD_W-1:0] prod_r;

  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] alu_res;

  // divider
  logic [WORD_W-1:0] dvd_r, rem_r, dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              div_run_r, div_run_nxt;
  logic              neg_q_r, neg_rem_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W+1:0] diff;
  logic              ge;
  logic [WORD_W-1:0] quo_s, rem_s;

  logic [1:0]        res_kind_r;
  logic [WORD_W-1:0] res_value_r;
  logic [2:0]        res_status_r;

  assign sp_m1 = sp_r - SP_W'(1);
  assign sp_m2 = sp_r - SP_W'(2);

  always_comb begin
    case (cmd_r)
      OP_PUSH:  push_word = {{8{imm_r[23]}}, imm_r};
      OP_RDCHR: push_word = {{(WORD_W-8){1'b0}}, rv_r[7:0]};
      default:  push_word = rv_r;
    endcase
  end

  assign shifted = {rem_r, dvd_r[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~diff[WORD_W+1];
  assign quo_s   = neg_q_r ? (WORD_W'(0) - dvd_r) : dvd_r;
  assign rem_s   = neg_rem_r ? (WORD_W'(0) - rem_r) : rem_r;

  always_comb begin
    case (cmd.alu_sel)
      ALU_ADD: alu_res = rd_a_r + rd_b_r;
      ALU_SUB: alu_res = rd_a_r - rd_b_r;
      ALU_MUL: alu_res = prod_r;
      ALU_DIV: alu_res = quo_s;
      ALU_MOD: alu_res = rem_s;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.push) begin
      sp_nxt = sp_r + SP_W'(1);
    end else if (cmd.reduce || cmd.pop) begin
      sp_nxt = sp_m1;
    end
    halted_nxt = halted_r | cmd.set_halt;
  end

  always_comb begin
    div_run_nxt = div_run_r;
    cnt_nxt     = cnt_r;
    if (cmd.div_start) begin
      div_run_nxt = 1'b1;
      cnt_nxt     = CNT_W'(WORD_W);
    end else if (div_run_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        div_run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      halted_r  <= 1'b0;
      div_run_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      sp_r      <= sp_nxt;
      halted_r  <= halted_nxt;
      div_run_r <= div_run_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // stack memory: one write port, two registered read ports at top and next-to-top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[sp_r[ADDR_W-1:0]] <= push_word;
    end else if (cmd.reduce) begin
      mem[sp_m2[ADDR_W-1:0]] <= alu_res;
    end
    rd_a_r <= mem[sp_m2[ADDR_W-1:0]];
    rd_b_r <= mem[sp_m1[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      imm_r <= in_immediate;
      rv_r  <= in_read_value;
    end
    if (cmd.mul_start) begin
      prod_r <= WORD_W'(rd_a_r * rd_b_r);
    end
    if (cmd.div_start) begin
      dvd_r     <= rd_a_r[WORD_W-1] ? (WORD_W'(0) - rd_a_r) : rd_a_r;
      dvs_r     <= rd_b_r[WORD_W-1] ? (WORD_W'(0) - rd_b_r) : rd_b_r;
      rem_r     <= '0;
      neg_q_r   <= rd_a_r[WORD_W-1] ^ rd_b_r[WORD_W-1];
      neg_rem_r <= rd_a_r[WORD_W-1];
    end else if (div_run_r) begin
      rem_r <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      dvd_r <= {dvd_r[WORD_W-2:0], ge};
    end
    if (cmd.set_res) begin
      res_kind_r   <= cmd.res_kind;
      res_status_r <= cmd.res_status;
      case (cmd.res_kind)
        WK_INT:  res_value_r <= rd_b_r;
        WK_CHR:  res_value_r <= {{(WORD_W-8){1'b0}}, rd_b_r[7:0]};
        default: res_value_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_write_kind  <= res_kind_r;
      out_write_value <= res_value_r;
      out_status      <= res_status_r;
      out_depth       <= DEPTH_W'(sp_r);
    end
  end

  assign stat.cmd          = cmd_r;
  assign stat.halted       = halted_r;
  assign stat.sp_full      = (sp_r >= SP_W'(STACK_DEPTH));
  assign stat.sp_lt1       = (sp_r == '0);
  assign stat.sp_lt2       = (sp_r < SP_W'(2));
  assign stat.divisor_zero = (rd_b_r == '0);
  assign stat.div_busy     = div_run_r;

endmodule

// ----- hdl/smx_ctrl.sv -----
// controller: instruction sequencing state machine and output handshake
`timescale 1ns / 1ps

module smx_ctrl
  import smx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = ~out_valid_r | out_ready;

  always_comb begin
    cmd            = '0;
    cmd.alu_sel    = ALU_ADD;
    cmd.res_status = ST_OK;
    cmd.res_kind   = WK_NONE;
    state_nxt      = state_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end

      S_DEC: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_FIN;
        if (stat.halted) begin
          cmd.res_status = ST_IGNORED;
        end else if (stat.cmd == OP_HALT) begin
          cmd.set_halt   = 1'b1;
          cmd.res_status = ST_HALTED;
        end else if (stat.cmd inside {OP_PUSH, OP_RDINT, OP_RDCHR}) begin
          if (stat.sp_full) begin
            cmd.res_status = ST_OVF;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (stat.cmd inside {[OP_ADD:OP_MOD]}) begin
          if (stat.sp_lt2) begin
            cmd.res_status = ST_UNF;
          end else if ((stat.cmd inside {OP_DIV, OP_MOD}) && stat.divisor_zero) begin
            cmd.res_status = ST_DIVZ;
          end else if (stat.cmd == OP_MUL) begin
            cmd.set_res   = 1'b0;
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end else if (stat.cmd inside {OP_DIV, OP_MOD}) begin
            cmd.set_res   = 1'b0;
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            cmd.reduce  = 1'b1;
            cmd.alu_sel = (stat.cmd == OP_SUB) ? ALU_SUB : ALU_ADD;
          end
        end else if (stat.cmd inside {OP_WRINT, OP_WRCHR}) begin
          if (stat.sp_lt1) begin
            cmd.res_status = ST_UNF;
          end else begin
            cmd.pop      = 1'b1;
            cmd.res_kind = (stat.cmd == OP_WRCHR) ? WK_CHR : WK_INT;
          end
        end
      end

      S_MUL: begin
        cmd.reduce  = 1'b1;
        cmd.alu_sel = ALU_MUL;
        cmd.set_res = 1'b1;
        state_nxt   = S_FIN;
      end

      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.reduce  = 1'b1;
          cmd.alu_sel = (stat.cmd == OP_MOD) ? ALU_MOD : ALU_DIV;
          cmd.set_res = 1'b1;
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/stack_machine_executor.sv -----
// top level: stack machine executor, one instruction per input transfer
// sequence: capture, decode, output load; mul adds a multiply state, div and mod a divide
//   loop (serial divider, one quotient bit per cycle); plus any wait for the output to drain
// throughput: one instruction at a time; the next transfer waits for the output load
// reset: synchronous active-low rst_n clears stack pointer, halted flag and handshake state;
//   stack contents are undefined until pushed
`timescale 1ns / 1ps

module stack_machine_executor
  import smx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // instruction channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_command,
  input  logic [23:0]              in_immediate,
  input  logic signed [WORD_W-1:0] in_read_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_write_kind,
  output logic signed [WORD_W-1:0] out_write_value,
  output logic [2:0]               out_status,
  output logic [DEPTH_W-1:0]       out_depth
);

  // controller to datapath commands, datapath to controller flags
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic [WORD_W-1:0] write_value;

  // sequencer: idle -> decode -> (mul | divide loop) -> output load
  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // stack memory, arithmetic units and the output register
  smx_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_command      (in_command),
    .in_immediate    (in_immediate),
    .in_read_value   (in_read_value),
    .out_write_kind  (out_write_kind),
    .out_write_value (write_value),
    .out_status      (out_status),
    .out_depth       (out_depth)
  );

  // result word leaves as a signed field
  assign out_write_value = write_value;

endmodule

// ----- tb/tb_stack_machine_executor.sv -----
// testbench: stack machine executor, directed table, random programs, then halt rows, predictor-checked
`timescale 1ns / 1ps

module tb_stack_machine_executor
  import smx_pkg::*;
();

  // unknown opcode range, anything above the last defined one
  localparam logic [7:0] OP_FIRST_UNKNOWN = OP_WRCHR + 8'd1;
  localparam logic [7:0] OP_LAST_UNKNOWN  = 8'hFF;
  localparam int RANDOM_ITEMS = 1350;
  // quiet stretch of the random part: no idling on either side
  localparam int STEADY_FIRST = 500;
  localparam int STEADY_LAST  = 800;

  typedef struct packed {
    logic [7:0]        command;
    logic [23:0]       immediate;
    logic [WORD_W-1:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [1:0]         write_kind;
    logic [WORD_W-1:0]  write_value;
    logic [2:0]         status;
    logic [DEPTH_W-1:0] depth;
  } result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    instr_t  instr;
    logic    typed;
    result_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_command = '0;
  logic [23:0] in_immediate = '0;
  logic signed [WORD_W-1:0] in_read_value = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [1:0] out_write_kind;
  logic signed [WORD_W-1:0] out_write_value;
  logic [2:0] out_status;
  logic [DEPTH_W-1:0] out_depth;

  // predictor state
  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int stack_count = 0;
  bit machine_halted = 1'b0;

  result_t pending_results[$];
  dir_row_t directed_rows[$];
  dir_row_t halt_rows[$];
  int errors = 0;
  bit no_idle = 1'b0;

  logic [7:0] push_ops  [3] = '{OP_PUSH, OP_RDINT, OP_RDCHR};
  logic [7:0] arith_ops [5] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD};
  logic [7:0] write_ops [2] = '{OP_WRINT, OP_WRCHR};

  stack_machine_executor u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_immediate    (in_immediate),
    .in_read_value   (in_read_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_kind  (out_write_kind),
    .out_write_value (out_write_value),
    .out_status      (out_status),
    .out_depth       (out_depth)
  );

  always #5 clk = ~clk;

  // executes one instruction on the predictor's stack and returns what the block should report
  function automatic result_t run_instruction(instr_t it);
    result_t r;
    logic [WORD_W-1:0] a, b, w, ua, ub;
    r = '0;
    w = '0;
    if (machine_halted) begin
      r.status = ST_IGNORED;
    end else begin
      case (it.command)
        OP_HALT: begin
          machine_halted = 1'b1;
          r.status = ST_HALTED;
        end
        OP_PUSH, OP_RDINT, OP_RDCHR: begin
          if (stack_count >= STACK_DEPTH) begin
            r.status = ST_OVF;
          end else begin
            if (it.command == OP_PUSH) w = {{8{it.immediate[23]}}, it.immediate};
            else if (it.command == OP_RDINT) w = it.read_value;
            else w = {24'd0, it.read_value[7:0]};
            stack_words[stack_count] = w;
            stack_count++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          if (stack_count < 2) begin
            r.status = ST_UNF;
          end else begin
            a = stack_words[stack_count - 2];
            b = stack_words[stack_count - 1];
            if ((it.command == OP_DIV || it.command == OP_MOD) && b == '0) begin
              r.status = ST_DIVZ;
            end else begin
              // signed division on magnitudes so the most negative word wraps cleanly
              ua = a[WORD_W-1] ? -a : a;
              ub = b[WORD_W-1] ? -b : b;
              case (it.command)
                OP_ADD: w = a + b;
                OP_SUB: w = a - b;
                OP_MUL: w = a * b;
                OP_DIV: begin
                  w = ua / ub;
                  if (a[WORD_W-1] ^ b[WORD_W-1]) w = -w;
                end
                default: begin
                  // remainder follows the sign of the dividend
                  w = ua % ub;
                  if (a[WORD_W-1]) w = -w;
                end
              endcase
              stack_words[stack_count - 2] = w;
              stack_count--;
            end
          end
        end
        OP_WRINT, OP_WRCHR: begin
          if (stack_count < 1) begin
            r.status = ST_UNF;
          end else begin
            stack_count--;
            w = stack_words[stack_count];
            if (it.command == OP_WRCHR) begin
              r.write_kind = WK_CHR;
              r.write_value = {24'd0, w[7:0]};
            end else begin
              r.write_kind = WK_INT;
              r.write_value = w;
            end
          end
        end
        default: ;
      endcase
    end
    r.depth = DEPTH_W'(stack_count);
    return r;
  endfunction

  // row whose result comes from the predictor
  function automatic dir_row_t plain(logic [7:0] c, logic [23:0] imm, logic [WORD_W-1:0] rv);
    dir_row_t d;
    d = '0;
    d.instr = '{c, imm, rv};
    return d;
  endfunction

  // row with a result that writes nothing, known by inspection
  function automatic dir_row_t known(logic [7:0] c, logic [23:0] imm, logic [WORD_W-1:0] rv,
                                     logic [2:0] st, int d_after);
    dir_row_t d;
    d = plain(c, imm, rv);
    d.typed = 1'b1;
    d.result.status = st;
    d.result.depth = DEPTH_W'(d_after);
    return d;
  endfunction

  // one transfer on the instruction channel; the prediction is queued at the accepting edge
  task automatic send_instr(dir_row_t row);
    result_t predicted;
    if (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_command <= row.instr.command;
    in_immediate <= row.instr.immediate;
    in_read_value <= row.instr.read_value;
    do @(posedge clk); while (!in_ready);
    // predictor always runs so its stack tracks typed rows as well
    predicted = run_instruction(row.instr);
    pending_results.push_back(row.typed ? row.result : predicted);
    @(negedge clk);
  endtask

  // result channel back-pressure, off during the quiet stretch
  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_write_kind !== want.write_kind) begin
          $error("write_kind: expected %0d, got %0d", want.write_kind, out_write_kind);
          errors++;
        end
        if (out_write_value !== want.write_value) begin
          $error("write_value: expected %08h, got %08h", want.write_value, out_write_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, out_depth);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    int n, pick;
    logic [WORD_W-1:0] tiny;

    // empty stack errors and an unknown opcode first
    directed_rows.push_back(known(OP_ADD, 24'h0, 32'h0, ST_UNF, 0));
    directed_rows.push_back(known(OP_WRCHR, 24'h0, 32'h0, ST_UNF, 0));
    directed_rows.push_back(known(OP_LAST_UNKNOWN, 24'hFFFFFF, 32'hFFFFFFFF, ST_OK, 0));
    // immediate extremes and read value extremes
    directed_rows.push_back(plain(OP_PUSH, 24'h7FFFFF, 32'h0));
    directed_rows.push_back(plain(OP_PUSH, 24'h800000, 32'h0));
    directed_rows.push_back(plain(OP_RDINT, 24'h0, 32'h7FFFFFFF));
    directed_rows.push_back(plain(OP_RDINT, 24'h0, 32'h80000000));
    directed_rows.push_back(plain(OP_PUSH, 24'hFFFFFF, 32'h0));
    // most negative word divided by minus one wraps
    directed_rows.push_back(plain(OP_DIV, 24'h0, 32'h0));
    directed_rows.push_back(plain(OP_RDCHR, 24'h0, 32'hFFFFFF80));
    // zero divisor on top of the stack
    directed_rows.push_back(plain(OP_PUSH, 24'h0, 32'h0));
    directed_rows.push_back(known(OP_MOD, 24'h0, 32'h0, ST_DIVZ, 6));
    directed_rows.push_back(known(OP_DIV, 24'h0, 32'h0, ST_DIVZ, 6));
    // fill to the top, then overflow on every push kind
    directed_rows.push_back(plain(OP_PUSH, 24'h000001, 32'h0));
    directed_rows.push_back(plain(OP_RDINT, 24'h0, 32'hFFFFFFFF));
    directed_rows.push_back(known(OP_PUSH, 24'h123456, 32'h0, ST_OVF, STACK_DEPTH));
    directed_rows.push_back(known(OP_RDINT, 24'h0, 32'h55AA55AA, ST_OVF, STACK_DEPTH));
    directed_rows.push_back(known(OP_RDCHR, 24'h0, 32'hAA55AA55, ST_OVF, STACK_DEPTH));
    directed_rows.push_back(plain(OP_MUL, 24'h0, 32'h0));
    directed_rows.push_back(plain(OP_SUB, 24'h0, 32'h0));
    directed_rows.push_back(plain(OP_ADD, 24'h0, 32'h0));
    directed_rows.push_back(plain(OP_WRCHR, 24'h0, 32'h0));
    directed_rows.push_back(plain(OP_WRINT, 24'h0, 32'h0));
    // most negative word modulo minus one gives zero
    directed_rows.push_back(plain(OP_RDINT, 24'h0, 32'h80000000));
    directed_rows.push_back(plain(OP_PUSH, 24'hFFFFFF, 32'h0));
    directed_rows.push_back(plain(OP_MOD, 24'h0, 32'h0));

    // halt comes last since nothing clears it short of reset
    halt_rows.push_back(plain(OP_HALT, 24'h0, 32'h0));
    halt_rows.push_back(plain(OP_PUSH, 24'h000007, 32'h0));
    halt_rows.push_back(plain(OP_WRINT, 24'h0, 32'h0));
    halt_rows.push_back(plain(OP_LAST_UNKNOWN, 24'h0, 32'h0));
    halt_rows.push_back(plain(OP_HALT, 24'h0, 32'h0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_instr(directed_rows[i]);

    // random programs steered by the predicted depth so the stack keeps filling and draining
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= STEADY_FIRST && n < STEADY_LAST);
      pick = $urandom_range(99);
      tiny = WORD_W'($urandom_range(15));
      if ($urandom_range(1)) tiny = -tiny;
      row = '0;
      row.instr.immediate = $urandom_range(1) ? 24'($urandom) : tiny[23:0];
      row.instr.read_value = $urandom_range(1) ? WORD_W'($urandom) : tiny;
      if (pick < 5) begin
        row.instr.command = 8'($urandom_range(OP_LAST_UNKNOWN, OP_FIRST_UNKNOWN));
      end else if (pick < 10) begin
        // any defined opcode but halt regardless of depth, so errors show up mid-program
        row.instr.command = 8'($urandom_range(OP_WRCHR, OP_PUSH));
      end else if (stack_count < 2) begin
        if (stack_count == 1 && pick < 25) row.instr.command = write_ops[$urandom_range(1)];
        else row.instr.command = push_ops[$urandom_range(2)];
      end else if (stack_count >= STACK_DEPTH) begin
        if (pick < 20) row.instr.command = push_ops[$urandom_range(2)];
        else if (pick < 80) row.instr.command = arith_ops[$urandom_range(4)];
        else row.instr.command = write_ops[$urandom_range(1)];
      end else if (pick < 55) begin
        row.instr.command = push_ops[$urandom_range(2)];
      end else if (pick < 88) begin
        row.instr.command = arith_ops[$urandom_range(4)];
      end else begin
        row.instr.command = write_ops[$urandom_range(1)];
      end
      send_instr(row);
    end
    no_idle = 1'b0;

    foreach (halt_rows[i]) send_instr(halt_rows[i]);
    in_valid <= 1'b0;

    // drain, then keep watching for any stray transfer before the verdict
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
